// ----- hdl/gbp_pkg.sv -----
`default_nettype none

package gbp_pkg;

    // Default geometry of the grid and the obstacle table.
    localparam int DEF_GRID_COLS      = 64;
    localparam int DEF_GRID_ROWS      = 16;
    localparam int DEF_CELL_SHIFT     = 4;
    localparam int DEF_SLOTS_PER_CELL = 2;
    localparam int DEF_OBSTACLE_COUNT = 16;

    // Fixed field widths.
    localparam int CMD_W  = 3;
    localparam int IDX_W  = 4;
    localparam int X_W    = 10;
    localparam int Y_W    = 8;
    localparam int WH_W   = 8;
    localparam int SLOT_W = IDX_W + 1;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PLAYER     = 3'd0,
        CMD_ADD            = 3'd1,
        CMD_REMOVE         = 3'd2,
        CMD_MOVE           = 3'd3,
        CMD_QUERY_PLAYER   = 3'd4,
        CMD_QUERY_OBSTACLE = 3'd5
    } t_command;

    // Stored form of a box.
    typedef struct packed {
        logic [X_W-1:0]  left;
        logic [Y_W-1:0]  bottom;
        logic [WH_W-1:0] wide;
        logic [WH_W-1:0] tall;
    } t_box;

    // Edges of a box; the top may lie above zero and is then negative.
    typedef struct packed {
        logic signed [11:0] left;
        logic signed [11:0] right;
        logic signed [11:0] bottom;
        logic signed [11:0] top;
    } t_edges;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_write;
        logic load;
        logic write_player;
        logic store_box;
        logic start_walk;
        logic walk_use_new;
        logic walk_insert;
        logic cell_read;
        logic cell_write;
        logic slot_check;
        logic slot_next;
        logic cursor_step;
        logic hit_init;
    } t_ctrl;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic             clr_last;
        logic [CMD_W-1:0] cmd;
        logic             player_ok;
        logic             obst_ok;
        logic             query_ok;
        logic             span_differ;
        logic             is_query;
        logic             cell_last;
        logic             slot_last;
    } t_stat;

    function automatic t_edges box_edges(t_box b);
        t_edges     e;
        logic [10:0] r;
        r        = 11'(b.left) + 11'(b.wide);
        e.left   = $signed({2'b00, b.left});
        e.right  = $signed({1'b0, r});
        e.bottom = $signed({4'b0000, b.bottom});
        e.top    = $signed({4'b0000, b.bottom}) - $signed({4'b0000, b.tall});
        return e;
    endfunction

    // Inclusive overlap of two boxes.
    function automatic logic boxes_overlap(t_edges a, t_edges b);
        return (a.right >= b.left) && (a.left <= b.right) &&
               (a.bottom >= b.top) && (a.top <= b.bottom);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/gbp_if.sv -----
`default_nettype none

// Command channel: one transfer per command.
interface gbp_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [gbp_pkg::CMD_W-1:0]   command;
    logic [gbp_pkg::IDX_W-1:0]   item_index;
    logic [gbp_pkg::X_W-1:0]     pos_x;
    logic [gbp_pkg::Y_W-1:0]     pos_y;
    logic [gbp_pkg::WH_W-1:0]    box_width;
    logic [gbp_pkg::WH_W-1:0]    box_height;

    modport source (output valid, command, item_index, pos_x, pos_y, box_width,
                    box_height, input ready);
    modport sink (input valid, command, item_index, pos_x, pos_y, box_width,
                  box_height, output ready);
endinterface

// Result channel: one transfer per command.
interface gbp_hit_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink (input valid, hit, output ready);
endinterface

`default_nettype wire

// ----- hdl/gbp_ram.sv -----
`default_nettype none

module gbp_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/gbp_datapath.sv -----
`default_nettype none

module gbp_datapath #(
    parameter int GRID_COLS      = gbp_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS      = gbp_pkg::DEF_GRID_ROWS,
    parameter int CELL_SHIFT     = gbp_pkg::DEF_CELL_SHIFT,
    parameter int SLOTS_PER_CELL = gbp_pkg::DEF_SLOTS_PER_CELL,
    parameter int OBSTACLE_COUNT = gbp_pkg::DEF_OBSTACLE_COUNT
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire gbp_pkg::t_ctrl               i_ctrl,
    input  wire logic [gbp_pkg::CMD_W-1:0]    i_command,
    input  wire logic [gbp_pkg::IDX_W-1:0]    i_item_index,
    input  wire logic [gbp_pkg::X_W-1:0]      i_pos_x,
    input  wire logic [gbp_pkg::Y_W-1:0]      i_pos_y,
    input  wire logic [gbp_pkg::WH_W-1:0]     i_box_width,
    input  wire logic [gbp_pkg::WH_W-1:0]     i_box_height,
    output gbp_pkg::t_stat                    o_stat,
    output logic                              o_hit
);

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int CELLS = GRID_ROWS * GRID_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int OW    = (OBSTACLE_COUNT > 1) ? $clog2(OBSTACLE_COUNT) : 1;
    localparam int SLW   = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
    localparam int SW    = gbp_pkg::SLOT_W;
    localparam int LW    = SLOTS_PER_CELL * SW;
    localparam logic [AW-1:0] COLS_A = AW'(GRID_COLS);

    // Column of a pixel x, clamped to the last column.
    function automatic logic [CW-1:0] col_of(logic signed [11:0] v);
        logic [11:0] s;
        s = $unsigned(v) >> CELL_SHIFT;
        return (s > 12'(GRID_COLS - 1)) ? CW'(GRID_COLS - 1) : s[CW-1:0];
    endfunction

    // Row of a pixel y, zero above the field, clamped to the last row.
    function automatic logic [RW-1:0] row_of(logic signed [11:0] v);
        logic [11:0] s;
        s = $unsigned(v) >> CELL_SHIFT;
        if (v < 0) begin
            return '0;
        end
        return (s > 12'(GRID_ROWS - 1)) ? RW'(GRID_ROWS - 1) : s[RW-1:0];
    endfunction

    // Latched command.
    logic [gbp_pkg::CMD_W-1:0] r_cmd;
    logic [gbp_pkg::IDX_W-1:0] r_idx;
    gbp_pkg::t_box             r_qbox;

    // Stored boxes.
    gbp_pkg::t_box r_obst [OBSTACLE_COUNT];
    gbp_pkg::t_box r_player [2];

    // Cell cursor and walk state.
    logic [CW-1:0]  r_x0, r_x1, r_col;
    logic [RW-1:0]  r_y0, r_y1, r_row;
    logic           r_phase, r_sub, r_insert;
    logic [SLW-1:0] r_slot;
    logic [AW-1:0]  r_clr;
    logic           r_hit;

    logic [CW-1:0]  n_col;
    logic [RW-1:0]  n_row;
    logic           n_phase, n_sub, cell_last;

    gbp_pkg::t_edges q_e, o_e;
    gbp_pkg::t_box   obst_box;
    logic [gbp_pkg::IDX_W-1:0] obst_addr;
    logic [6:0]      obst_ext;
    logic [CW-1:0]   nx0, nx1, ox0, ox1, cur_col;
    logic [RW-1:0]   ny0, ny1, oy0, oy1, cur_row;
    logic [AW-1:0]   cell_addr;
    logic [LW-1:0]   rd_data, mod_data;
    logic [SW-1:0]   cur_slot, mslot;
    logic            mod_done, slot_hit, slot_ok, player_hit, is_query;
    logic            player_ok, top_ok, query_ok;
    integer          k;

    assign is_query  = (r_cmd == gbp_pkg::CMD_QUERY_PLAYER) ||
                       (r_cmd == gbp_pkg::CMD_QUERY_OBSTACLE);
    assign q_e       = gbp_pkg::box_edges(r_qbox);
    assign player_ok = (r_idx[gbp_pkg::IDX_W-1:1] == '0);
    assign top_ok    = !q_e.top[11];
    assign query_ok  = top_ok && ((r_cmd == gbp_pkg::CMD_QUERY_OBSTACLE) ||
                       ((r_cmd == gbp_pkg::CMD_QUERY_PLAYER) && player_ok));

    // One read point into the obstacle table: the slot's number while
    // scanning, otherwise the command's own number.
    assign cur_slot  = rd_data[r_slot*SW +: SW];
    assign obst_addr = i_ctrl.slot_check ? cur_slot[gbp_pkg::IDX_W-1:0] : r_idx;
    assign obst_ext  = 7'(obst_addr);
    assign obst_box  = r_obst[obst_ext[OW-1:0]];
    assign o_e       = gbp_pkg::box_edges(obst_box);

    // Cell ranges of the command's box and of the stored box.
    assign nx0 = col_of(q_e.left);
    assign nx1 = col_of(q_e.right);
    assign ny0 = row_of(q_e.top);
    assign ny1 = row_of(q_e.bottom);
    assign ox0 = col_of(o_e.left);
    assign ox1 = col_of(o_e.right);
    assign oy0 = row_of(o_e.top);
    assign oy1 = row_of(o_e.bottom);

    // Player test at the start of a query.
    always_comb begin
        player_hit = 1'b0;
        if (r_cmd == gbp_pkg::CMD_QUERY_PLAYER) begin
            player_hit = gbp_pkg::boxes_overlap(q_e,
                             gbp_pkg::box_edges(r_player[~r_idx[0]]));
        end else begin
            player_hit = gbp_pkg::boxes_overlap(q_e, gbp_pkg::box_edges(r_player[0])) ||
                         gbp_pkg::boxes_overlap(q_e, gbp_pkg::box_edges(r_player[1]));
        end
    end

    // Current cell: top and bottom rows first, then the two side columns.
    assign cur_row   = r_phase ? r_row : (r_sub ? r_y1 : r_y0);
    assign cur_col   = r_phase ? (r_sub ? r_x1 : r_x0) : r_col;
    assign cell_addr = AW'(cur_row) * COLS_A + AW'(cur_col);

    // Next cell of the perimeter walk.
    always_comb begin
        n_col     = r_col;
        n_row     = r_row;
        n_phase   = r_phase;
        n_sub     = r_sub;
        cell_last = 1'b0;
        if (!r_phase) begin
            if (!r_sub && (r_y1 != r_y0)) begin
                n_sub = 1'b1;
            end else begin
                n_sub = 1'b0;
                if (r_col != r_x1) begin
                    n_col = r_col + 1'b1;
                end else if (!is_query && ({1'b0, r_y1} > ({1'b0, r_y0} + 1'b1))) begin
                    n_phase = 1'b1;
                    n_row   = r_y0 + 1'b1;
                end else begin
                    cell_last = 1'b1;
                end
            end
        end else begin
            if (!r_sub && (r_x1 != r_x0)) begin
                n_sub = 1'b1;
            end else begin
                n_sub = 1'b0;
                if (({1'b0, r_row} + 1'b1) != {1'b0, r_y1}) begin
                    n_row = r_row + 1'b1;
                end else begin
                    cell_last = 1'b1;
                end
            end
        end
    end

    // Insert into the first free slot, or clear the first matching slot.
    always_comb begin
        mod_data = rd_data;
        mod_done = 1'b0;
        for (k = 0; k < SLOTS_PER_CELL; k++) begin
            mslot = rd_data[k*SW +: SW];
            if (!mod_done) begin
                if (r_insert) begin
                    if (!mslot[SW-1]) begin
                        mod_data[k*SW +: SW] = {1'b1, r_idx};
                        mod_done = 1'b1;
                    end
                end else if (mslot[SW-1] && (mslot[gbp_pkg::IDX_W-1:0] == r_idx)) begin
                    mod_data[k*SW +: SW] = '0;
                    mod_done = 1'b1;
                end
            end
        end
    end

    // Test of one slot against the query box.
    assign slot_ok  = cur_slot[SW-1] &&
                      (7'(cur_slot[gbp_pkg::IDX_W-1:0]) < 7'(OBSTACLE_COUNT)) &&
                      !((r_cmd == gbp_pkg::CMD_QUERY_OBSTACLE) &&
                        (cur_slot[gbp_pkg::IDX_W-1:0] == r_idx));
    assign slot_hit = slot_ok && gbp_pkg::boxes_overlap(q_e, o_e);

    gbp_ram #(
        .WIDTH (LW),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.clr_write | i_ctrl.cell_write),
        .i_waddr (i_ctrl.clr_write ? r_clr : cell_addr),
        .i_wdata (i_ctrl.clr_write ? '0 : mod_data),
        .i_re    (i_ctrl.cell_read),
        .i_raddr (cell_addr),
        .o_rdata (rd_data)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_player[0] <= '0;
            r_player[1] <= '0;
            r_hit       <= 1'b0;
            r_slot      <= '0;
        end else begin
            if (i_ctrl.clr_write) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_ctrl.write_player) begin
                r_player[r_idx[0]] <= r_qbox;
            end
            if (i_ctrl.hit_init) begin
                r_hit <= query_ok && player_hit;
            end else if (i_ctrl.slot_check && slot_hit) begin
                r_hit <= 1'b1;
            end
            if (i_ctrl.cell_read) begin
                r_slot <= '0;
            end else if (i_ctrl.slot_next) begin
                r_slot <= r_slot + 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_command;
            r_idx  <= i_item_index;
            r_qbox <= '{left: i_pos_x, bottom: i_pos_y, wide: i_box_width,
                        tall: i_box_height};
        end
        if (i_ctrl.store_box) begin
            r_obst[obst_ext[OW-1:0]] <= r_qbox;
        end
        if (i_ctrl.start_walk) begin
            r_x0     <= i_ctrl.walk_use_new ? nx0 : ox0;
            r_x1     <= i_ctrl.walk_use_new ? nx1 : ox1;
            r_y0     <= i_ctrl.walk_use_new ? ny0 : oy0;
            r_y1     <= i_ctrl.walk_use_new ? ny1 : oy1;
            r_col    <= i_ctrl.walk_use_new ? nx0 : ox0;
            r_phase  <= 1'b0;
            r_sub    <= 1'b0;
            r_insert <= i_ctrl.walk_insert;
        end else if (i_ctrl.cursor_step) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_phase <= n_phase;
            r_sub   <= n_sub;
        end
    end

    assign o_stat = '{
        clr_last:    (r_clr == AW'(CELLS - 1)),
        cmd:         r_cmd,
        player_ok:   player_ok,
        obst_ok:     (7'(r_idx) < 7'(OBSTACLE_COUNT)),
        query_ok:    query_ok,
        span_differ: (nx0 != ox0) || (nx1 != ox1) || (ny0 != oy0) || (ny1 != oy1),
        is_query:    is_query,
        cell_last:   cell_last,
        slot_last:   (r_slot == SLW'(SLOTS_PER_CELL - 1))
    };
    assign o_hit = r_hit;

endmodule

`default_nettype wire

// ----- hdl/gbp_controller.sv -----
`default_nettype none

module gbp_controller (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire gbp_pkg::t_stat i_stat,
    input  wire logic           i_in_valid,
    input  wire logic           i_out_ready,
    output gbp_pkg::t_ctrl      o_ctrl,
    output logic                o_in_ready,
    output logic                o_out_valid
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_DECIDE = 7'b0000100,
        S_READ   = 7'b0001000,
        S_MODIFY = 7'b0010000,
        S_SLOT   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_second <= n_second;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        o_ctrl      = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_ctrl.clr_write = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready  = 1'b1;
                o_ctrl.load = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                o_ctrl.hit_init = 1'b1;
                n_state         = S_OUT;
                n_second        = 1'b0;
                case (i_stat.cmd)
                    gbp_pkg::CMD_SET_PLAYER: begin
                        o_ctrl.write_player = i_stat.player_ok;
                    end
                    gbp_pkg::CMD_ADD: begin
                        if (i_stat.obst_ok) begin
                            o_ctrl.store_box    = 1'b1;
                            o_ctrl.start_walk   = 1'b1;
                            o_ctrl.walk_use_new = 1'b1;
                            o_ctrl.walk_insert  = 1'b1;
                            n_state             = S_READ;
                        end
                    end
                    gbp_pkg::CMD_REMOVE: begin
                        if (i_stat.obst_ok) begin
                            o_ctrl.start_walk = 1'b1;
                            n_state           = S_READ;
                        end
                    end
                    gbp_pkg::CMD_MOVE: begin
                        if (i_stat.obst_ok) begin
                            o_ctrl.store_box = 1'b1;
                            if (i_stat.span_differ) begin
                                o_ctrl.start_walk = 1'b1;
                                n_second          = 1'b1;
                                n_state           = S_READ;
                            end
                        end
                    end
                    gbp_pkg::CMD_QUERY_PLAYER, gbp_pkg::CMD_QUERY_OBSTACLE: begin
                        if (i_stat.query_ok) begin
                            o_ctrl.start_walk   = 1'b1;
                            o_ctrl.walk_use_new = 1'b1;
                            n_state             = S_READ;
                        end
                    end
                    default: begin
                        n_state = S_OUT;
                    end
                endcase
            end
            S_READ: begin
                o_ctrl.cell_read = 1'b1;
                n_state          = S_MODIFY;
            end
            S_MODIFY: begin
                if (i_stat.is_query) begin
                    n_state = S_SLOT;
                end else begin
                    o_ctrl.cell_write = 1'b1;
                    if (!i_stat.cell_last) begin
                        o_ctrl.cursor_step = 1'b1;
                        n_state            = S_READ;
                    end else if (r_second) begin
                        // Old range cleared: now enter the new one.
                        o_ctrl.start_walk   = 1'b1;
                        o_ctrl.walk_use_new = 1'b1;
                        o_ctrl.walk_insert  = 1'b1;
                        n_second            = 1'b0;
                        n_state             = S_READ;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_SLOT: begin
                o_ctrl.slot_check = 1'b1;
                if (!i_stat.slot_last) begin
                    o_ctrl.slot_next = 1'b1;
                end else if (!i_stat.cell_last) begin
                    o_ctrl.cursor_step = 1'b1;
                    n_state            = S_READ;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/grid_broad_phase_collision.sv -----
// Broad-phase collision block on a uniform grid of cells.
// Commands arrive on the i_in channel (command, item_index, box fields); each
// command gives exactly one transfer on the o_out channel carrying hit,
// which is zero for every command other than a query.
// After reset the block clears the cell memory, one cell per cycle, all
// GRID_ROWS * GRID_COLS cells (1024 by default); i_in.ready stays low meanwhile.
// Commands are handled one at a time: i_in.ready is high only while the block
// waits for a command, and the result is held on o_out until it is taken,
// so a stalled receiver simply holds the block.
// Work from the command transfer to the result being offered:
//   set player, or any command that touches no cell: no cell access;
//   add, remove: a read and a write per cell on the perimeter of the cell range;
//   move with a changed range: a read and a write per old cell, then per new cell;
//   query: per cell of the top and bottom rows, a read and SLOTS_PER_CELL tests.
// The cell memory is read and then written in separate states, through one write
// port and one registered read port, and slots are tested one per cycle.
`default_nettype none

module grid_broad_phase_collision #(
    parameter int GRID_COLS      = gbp_pkg::DEF_GRID_COLS,
    parameter int GRID_ROWS      = gbp_pkg::DEF_GRID_ROWS,
    parameter int CELL_SHIFT     = gbp_pkg::DEF_CELL_SHIFT,
    parameter int SLOTS_PER_CELL = gbp_pkg::DEF_SLOTS_PER_CELL,
    parameter int OBSTACLE_COUNT = gbp_pkg::DEF_OBSTACLE_COUNT
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    gbp_cmd_if.sink    i_in,
    gbp_hit_if.source  o_out
);

    gbp_pkg::t_ctrl w_ctrl;
    gbp_pkg::t_stat w_stat;
    logic           w_in_ready;
    logic           w_out_valid;
    logic           w_hit;

    gbp_controller u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stat      (w_stat),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .o_ctrl      (w_ctrl),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid)
    );

    gbp_datapath #(
        .GRID_COLS      (GRID_COLS),
        .GRID_ROWS      (GRID_ROWS),
        .CELL_SHIFT     (CELL_SHIFT),
        .SLOTS_PER_CELL (SLOTS_PER_CELL),
        .OBSTACLE_COUNT (OBSTACLE_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_ctrl),
        .i_command    (i_in.command),
        .i_item_index (i_in.item_index),
        .i_pos_x      (i_in.pos_x),
        .i_pos_y      (i_in.pos_y),
        .i_box_width  (i_in.box_width),
        .i_box_height (i_in.box_height),
        .o_stat       (w_stat),
        .o_hit        (w_hit)
    );

    assign i_in.ready  = w_in_ready;
    assign o_out.valid = w_out_valid;
    assign o_out.hit   = w_hit;

`ifndef SYNTH
    // A result is never offered while a new command can be taken.
    a_out_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("result offered while accepting a command");

    // A command transfer is never answered in the very next cycle.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !o_out.valid)
        else $error("result offered too early");

    // A result transfer returns the block to waiting for a command.
    a_ret_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready) |=> (i_in.ready && !o_out.valid))
        else $error("block not ready after result transfer");
`endif

endmodule

`default_nettype wire
